// ===== design/brs_pkg.sv =====
// Package with constants, payload types and helpers for the bit vector rank/select block.
`default_nettype none
package brs_pkg;

  localparam int MAX_BITS  = 1024;
  localparam int WORD_BITS = 64;
  localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = $clog2(NUM_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PC_W      = BIT_W + 1;
  localparam int LEN_W     = 11;
  localparam int POS_W     = 10;
  localparam int MODE_W    = 3;

  localparam logic [MODE_W-1:0] MODE_READ  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILL  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIND  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_WALK,
    ST_SEL,
    ST_FIN
  } brs_state_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  index_first;
    logic [LEN_W-1:0]  index_end;
    logic              bit_value;
    logic [POS_W-1:0]  rank_target;
  } brs_in_t;

  typedef struct packed {
    logic              bit_out;
    logic              changed;
    logic [LEN_W-1:0]  ones_count;
    logic [POS_W-1:0]  found_position;
    logic              found;
  } brs_out_t;

  // Bits of the word starting at global index base that fall in [lo, hi).
  function automatic logic [WORD_BITS-1:0] range_mask(
    input logic [LEN_W:0] base,
    input logic [LEN_W:0] lo,
    input logic [LEN_W:0] hi
  );
    logic [WORD_BITS-1:0] lo_m;
    logic [WORD_BITS-1:0] hi_m;
    logic [LEN_W:0]       top;
    logic [LEN_W:0]       d_lo;
    logic [LEN_W:0]       d_hi;
    top  = base + (LEN_W+1)'(WORD_BITS);
    d_lo = lo - base;
    d_hi = hi - base;
    if (lo <= base) begin
      lo_m = '1;
    end else if (lo >= top) begin
      lo_m = '0;
    end else begin
      lo_m = {WORD_BITS{1'b1}} << d_lo[BIT_W-1:0];
    end
    if (hi >= top) begin
      hi_m = '1;
    end else if (hi <= base) begin
      hi_m = '0;
    end else begin
      hi_m = ~({WORD_BITS{1'b1}} << d_hi[BIT_W-1:0]);
    end
    return lo_m & hi_m;
  endfunction

endpackage
`default_nettype wire

// ===== design/brs_popcount.sv =====
// Shared population count unit over one word.
`default_nettype none
module brs_popcount
  import brs_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] word_i,
  output logic      [PC_W-1:0]      count_o
);

  // Heap-ordered adder tree: leaves hold the bits, each inner node adds its two children.
  logic [PC_W-1:0] node [2*WORD_BITS-1];

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      node[WORD_BITS-1+k] = PC_W'(word_i[k]);
    end
    for (int k = WORD_BITS - 2; k >= 0; k--) begin
      node[k] = node[2*k+1] + node[2*k+2];
    end
    count_o = node[0];
  end

endmodule
`default_nettype wire

// ===== design/bit_vector_rank_select.sv =====
// Top level of the bit vector with read, write, fill, rank and select operations.
// Usage: an item on in_data_i transfers when in_valid_i is high and in_stall_o low.
// Each item yields one result on out_data_o, which transfers when out_valid_o is
// high and out_stall_i low. The user must write the bit_length register through
// cfg_we_i and cfg_wdata_i only while the block is idle; it does not enforce this.
// Read and write pass through the ONE and FIN states to the output register. Fill,
// count and find walk the touched words one per cycle, count and find through a shared
// population count, then pass through FIN; up to 16 words are walked. A find that
// hits adds 6 halving steps inside the word, one per cycle, before FIN.
// One item is worked on at a time; in_stall_o is high while it is in progress.
// A finished result waits in an output register, so the next item transfers
// while the receiver stalls; a second result waits until the first is taken.
// Reset clears the whole vector at once and sets bit_length to 1024.
`default_nettype none
module bit_vector_rank_select
  import brs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [LEN_W-1:0] cfg_wdata_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire brs_in_t          in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output brs_out_t              out_data_o
);

  logic [WORD_BITS-1:0] words_q [NUM_WORDS];

  brs_state_e           state_q, state_d;
  logic [LEN_W-1:0]     len_q;
  logic [MODE_W-1:0]    mode_q, mode_d;
  logic [LEN_W-1:0]     first_q, first_d;
  logic [LEN_W-1:0]     hi_q, hi_d;
  logic                 val_q, val_d;
  logic [POS_W-1:0]     rank_q, rank_d;
  logic [WIDX_W-1:0]    w_q, w_d;
  logic [WORD_BITS-1:0] sw_q, sw_d;
  logic [LEN_W-1:0]     p_q, p_d;
  logic [2:0]           step_q, step_d;
  brs_out_t             res_q, res_d;
  brs_out_t             out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 mem_we;
  logic [WIDX_W-1:0]    mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     end_c;
  logic [WORD_BITS-1:0] rd_word;
  logic [LEN_W:0]       base;
  logic [WORD_BITS-1:0] mask;
  logic [BIT_W:0]       half;
  logic [WORD_BITS-1:0] low_mask;
  logic [WORD_BITS-1:0] pc_in;
  logic [PC_W-1:0]      pc;
  logic [POS_W-1:0]     pc_ext;
  logic                 last_word;
  logic                 cur_bit;

  brs_popcount u_popcount (
    .word_i  (pc_in),
    .count_o (pc)
  );

  always_comb begin
    len_eff   = (len_q > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : len_q;
    end_c     = (in_data_i.index_end > len_eff) ? len_eff : in_data_i.index_end;
    rd_word   = words_q[mem_addr];
    base      = (LEN_W+1)'({w_q, {BIT_W{1'b0}}});
    mask      = range_mask(base, {1'b0, first_q}, {1'b0, hi_q});
    half      = (BIT_W+1)'(WORD_BITS / 2) >> step_q;
    low_mask  = ~({WORD_BITS{1'b1}} << half);
    pc_in     = (state_q == ST_SEL) ? (sw_q & low_mask) : (rd_word & mask);
    pc_ext    = POS_W'(pc);
    last_word = (w_q == WIDX_W'(NUM_WORDS - 1)) ||
                ((base + (LEN_W+1)'(WORD_BITS)) >= {1'b0, hi_q});
    cur_bit   = rd_word[first_q[BIT_W-1:0]];
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    first_d     = first_q;
    hi_d        = hi_q;
    val_d       = val_q;
    rank_d      = rank_q;
    w_d         = w_q;
    sw_d        = sw_q;
    p_d         = p_q;
    step_d      = step_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mem_we      = 1'b0;
    mem_addr    = (state_q == ST_ONE) ? first_q[BIT_W+WIDX_W-1:BIT_W] : w_q;
    mem_wdata   = rd_word;
    in_stall_o  = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d  = in_data_i.mode;
          first_d = in_data_i.index_first;
          val_d   = in_data_i.bit_value;
          rank_d  = in_data_i.rank_target;
          w_d     = in_data_i.index_first[BIT_W+WIDX_W-1:BIT_W];
          step_d  = '0;
          res_d   = '0;
          hi_d    = (in_data_i.mode == MODE_FILL || in_data_i.mode == MODE_COUNT) ?
                    end_c : len_eff;
          case (in_data_i.mode)
            MODE_READ, MODE_WRITE: state_d = ST_ONE;
            MODE_FILL, MODE_COUNT, MODE_FIND: begin
              state_d = (in_data_i.index_first >= hi_d) ? ST_FIN : ST_WALK;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_ONE: begin
        if (first_q < hi_q) begin
          if (mode_q == MODE_READ) begin
            res_d.bit_out = cur_bit;
          end else begin
            res_d.changed = (cur_bit != val_q);
            mem_we        = 1'b1;
            mem_wdata     = rd_word;
            mem_wdata[first_q[BIT_W-1:0]] = val_q;
          end
        end
        state_d = ST_FIN;
      end
      ST_WALK: begin
        case (mode_q)
          MODE_FILL: begin
            mem_we    = 1'b1;
            mem_wdata = (rd_word & ~mask) | (val_q ? mask : '0);
          end
          MODE_COUNT: begin
            res_d.ones_count = res_q.ones_count + LEN_W'(pc);
          end
          default: begin
            if (rank_q < pc_ext) begin
              sw_d    = rd_word & mask;
              p_d     = base[LEN_W-1:0];
              state_d = ST_SEL;
            end else begin
              rank_d = rank_q - pc_ext;
            end
          end
        endcase
        w_d = w_q + WIDX_W'(1);
        if (last_word && state_d != ST_SEL) begin
          state_d = ST_FIN;
        end
      end
      ST_SEL: begin
        // Keep the lower half if it holds the sought one; step into the upper half otherwise.
        if (rank_q >= pc_ext) begin
          rank_d = rank_q - pc_ext;
          p_d    = p_q + LEN_W'(half);
          sw_d   = sw_q >> half;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'(BIT_W - 1)) begin
          res_d.found          = 1'b1;
          res_d.found_position = p_d[POS_W-1:0];
          state_d              = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        words_q[k] <= '0;
      end
    end else if (mem_we) begin
      words_q[mem_addr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      len_q       <= LEN_W'(MAX_BITS);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q  <= mode_d;
    first_q <= first_d;
    hi_q    <= hi_d;
    val_q   <= val_d;
    rank_q  <= rank_d;
    w_q     <= w_d;
    sw_q    <= sw_d;
    p_q     <= p_d;
    step_q  <= step_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
